// ===== rtl/ddpi_pkg.sv =====
// Package for the differential-drive pose integrator: widths, fixed-point
// constants, CORDIC arctangent table, state and command types.
// No dependencies; imported by every module of the block.
`default_nettype none

package ddpi_pkg;

  // CORDIC iteration count (8..24) and sequencer counter width
  localparam int CordicSteps = 16;
  localparam int CntW        = $clog2(CordicSteps);

  // cycles from presenting a dividend to the registered quotient
  localparam int DivLat = 3;

  // field widths
  localparam int SpdW  = 16;  // speed, turn rate (Q4.12)
  localparam int PerW  = 10;  // period in ms
  localparam int HeadW = 16;  // heading (Q3.13)
  localparam int PosW  = 32;  // position (Q16.16)

  // internal widths
  localparam int AngW   = 18;            // heading arithmetic before the wrap
  localparam int XyW    = 33;            // CORDIC x/y, Q2.30 with headroom
  localparam int ZW     = 35;            // CORDIC residual angle, Q2.30
  localparam int SpW    = 27;            // speed*period and rate*period
  localparam int ProdW  = XyW + SpW;     // cos/sin times speed*period
  localparam int DivTW  = 32;            // dividend magnitude
  localparam int DivQW  = 26;            // quotient magnitude
  localparam int DivDW  = 9;             // divisor width
  localparam int RecipW = 29;            // reciprocal width
  localparam int RecipShift = 35;        // reciprocal scale 2^35
  localparam int DivPW  = DivTW + RecipW;

  // heading in Q3.13
  localparam logic signed [AngW-1:0] PiQ13     = 18'sd25736;
  localparam logic signed [AngW-1:0] TwoPiQ13  = 18'sd51472;
  localparam logic signed [AngW-1:0] HalfPiQ13 = 18'sd12868;

  // CORDIC constants in Q2.30
  localparam logic signed [ZW-1:0]  PiQ30   = 35'sd3373259426;
  localparam logic signed [XyW-1:0] GainQ30 = 33'sd652032874;
  localparam int ZAlign = 17;  // Q3.13 -> Q2.30

  // rounding: rate*per/500 and cos*spd*per*16/(1000*2^30)
  localparam logic [DivTW-1:0] StepRound = 32'd250;
  localparam logic [ProdW:0]   PosRound  = (ProdW + 1)'(125) << 28;
  localparam int PosShift = 29;

  localparam logic [DivDW-1:0]  Div500   = 9'd500;
  localparam logic [DivDW-1:0]  Div125   = 9'd125;
  localparam logic [RecipW-1:0] Recip500 = 29'd68719476;   // floor(2^35/500)
  localparam logic [RecipW-1:0] Recip125 = 29'd274877906;  // floor(2^35/125)

  localparam logic [PerW-1:0] PeriodReset = 10'd10;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_PREP,
    ST_ROT,
    ST_MUL_C,
    ST_MUL_S,
    ST_DIV_W1,
    ST_DIV_W2,
    ST_UPD_X,
    ST_UPD_Y,
    ST_OUT
  } state_e;

  typedef enum logic {
    DIV_STEP,  // turn step: rate*per / 500
    DIV_POS    // position step: product / (125*2^29)
  } div_src_e;

  typedef struct packed {
    logic            accept;   // input beat taken this cycle
    logic            prep;     // scale inputs, seed CORDIC
    logic            rot;      // one CORDIC iteration
    logic [CntW-1:0] rot_idx;
    div_src_e        div_src;
    logic            step_ld;  // capture turn step quotient
    logic            mul_c;
    logic            mul_s;
    logic            upd_x;
    logic            upd_y;    // also updates heading
    logic            out_ld;
  } dp_cmd_t;

  typedef struct packed {
    logic in_load;  // current input beat is a pose load
  } dp_sts_t;

  // truncated Q2.30 arctangent of 2^-i
  function automatic logic [29:0] atan_q30(input logic [4:0] idx);
    logic [29:0] r;
    case (idx)
      5'd0:    r = 30'h3243F6A8;
      5'd1:    r = 30'h1DAC6705;
      5'd2:    r = 30'h0FADBAFC;
      5'd3:    r = 30'h07F56EA6;
      5'd4:    r = 30'h03FEAB76;
      5'd5:    r = 30'h01FFD55B;
      5'd6:    r = 30'h00FFFAAA;
      5'd7:    r = 30'h007FFF55;
      5'd8:    r = 30'h003FFFEA;
      5'd9:    r = 30'h001FFFFD;
      5'd10:   r = 30'h000FFFFF;
      5'd11:   r = 30'h0007FFFF;
      5'd12:   r = 30'h0003FFFF;
      5'd13:   r = 30'h0001FFFF;
      5'd14:   r = 30'h0000FFFF;
      5'd15:   r = 30'h00007FFF;
      5'd16:   r = 30'h00003FFF;
      5'd17:   r = 30'h00001FFF;
      5'd18:   r = 30'h00000FFF;
      5'd19:   r = 30'h000007FF;
      5'd20:   r = 30'h000003FF;
      5'd21:   r = 30'h000001FF;
      5'd22:   r = 30'h000000FF;
      5'd23:   r = 30'h0000007F;
      default: r = '0;
    endcase
    return r;
  endfunction

  // single wrap into (-pi, pi]
  function automatic logic signed [AngW-1:0] wrap_once(input logic signed [AngW-1:0] a);
    logic signed [AngW-1:0] r;
    if (a > PiQ13) begin
      r = a - TwoPiQ13;
    end else if (a <= -PiQ13) begin
      r = a + TwoPiQ13;
    end else begin
      r = a;
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/ddpi_div.sv =====
// Pipelined divider by a constant (500 or 125), giving the floor quotient from a reciprocal
// multiply and one correction step. Three register stages, no stall.
// Depends on ddpi_pkg.
`default_nettype none

module ddpi_div (
  input  wire                        clk_i,
  input  wire [ddpi_pkg::DivTW-1:0]  t_i,    // dividend magnitude
  input  wire                        neg_i,  // sign carried along
  input  ddpi_pkg::div_src_e         sel_i,
  output logic [ddpi_pkg::DivQW-1:0] q_o,
  output logic                       neg_o
);
  import ddpi_pkg::*;

  logic [DivTW-1:0] t1_q, t2_q;
  logic             neg1_q, neg2_q, neg3_q;
  div_src_e         sel1_q, sel2_q;
  logic [DivPW-1:0] prod2_q;
  logic [DivQW-1:0] q3_q;

  logic [RecipW-1:0] recip;
  logic [DivDW-1:0]  dvsr;
  logic [DivQW-1:0]  q_est;
  logic [DivTW-1:0]  qd;
  logic [DivTW-1:0]  rem;
  logic [DivQW-1:0]  q_fix;

  // reciprocal for stage 1, quotient estimate and correction for stage 2
  always_comb begin
    recip = (sel1_q == DIV_STEP) ? Recip500 : Recip125;
    dvsr  = (sel2_q == DIV_STEP) ? Div500 : Div125;
    q_est = prod2_q[DivPW-1 -: DivQW];
    qd    = DivTW'(q_est) * DivTW'(dvsr);
    rem   = t2_q - qd;
    q_fix = (rem >= DivTW'(dvsr)) ? q_est + 1'b1 : q_est;
  end

  // payload pipeline, advances every cycle
  always_ff @(posedge clk_i) begin
    t1_q    <= t_i;
    neg1_q  <= neg_i;
    sel1_q  <= sel_i;
    prod2_q <= DivPW'(t1_q) * DivPW'(recip);
    t2_q    <= t1_q;
    neg2_q  <= neg1_q;
    sel2_q  <= sel1_q;
    q3_q    <= q_fix;
    neg3_q  <= neg2_q;
  end

  assign q_o   = q3_q;
  assign neg_o = neg3_q;

endmodule

`default_nettype wire

// ===== rtl/ddpi_ctrl.sv =====
// Sequencer for the pose integrator: input/output handshake, CORDIC
// iteration counter and the per-state datapath commands.
// Depends on ddpi_pkg.
`default_nettype none

module ddpi_ctrl (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  output logic                out_valid_o,
  input  wire                 out_ready_i,
  input  ddpi_pkg::dp_sts_t   sts_i,
  output ddpi_pkg::dp_cmd_t   cmd_o
);
  import ddpi_pkg::*;

  state_e          state_q, state_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic            out_valid_q, out_valid_d;
  logic            out_free;

  assign out_free = !out_valid_q || out_ready_i;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          state_d = sts_i.in_load ? ST_OUT : ST_PREP;
        end
      end
      ST_PREP:   state_d = ST_ROT;
      ST_ROT: begin
        if (cnt_q == CntW'(CordicSteps - 1)) begin
          state_d = ST_MUL_C;
        end
      end
      ST_MUL_C:  state_d = ST_MUL_S;
      ST_MUL_S:  state_d = ST_DIV_W1;
      ST_DIV_W1: state_d = ST_DIV_W2;
      ST_DIV_W2: state_d = ST_UPD_X;
      ST_UPD_X:  state_d = ST_UPD_Y;
      ST_UPD_Y:  state_d = ST_OUT;
      ST_OUT: begin
        if (out_free) begin
          state_d = ST_IDLE;
        end
      end
      default:   state_d = ST_IDLE;
    endcase
  end

  // commands, counter, output valid
  always_comb begin
    cmd_o         = '0;
    cmd_o.rot_idx = cnt_q;
    cmd_o.div_src = DIV_POS;
    in_ready_o    = 1'b0;
    cnt_d         = '0;
    out_valid_d   = out_ready_i ? 1'b0 : out_valid_q;
    unique case (state_q)
      ST_IDLE: begin
        in_ready_o   = 1'b1;
        cmd_o.accept = in_valid_i;
      end
      ST_PREP:  cmd_o.prep = 1'b1;
      ST_ROT: begin
        cmd_o.rot = 1'b1;
        cnt_d     = cnt_q + 1'b1;
        // turn step division runs alongside the rotations
        if (cnt_q == '0) begin
          cmd_o.div_src = DIV_STEP;
        end
        if (cnt_q == CntW'(DivLat)) begin
          cmd_o.step_ld = 1'b1;
        end
      end
      ST_MUL_C: cmd_o.mul_c = 1'b1;
      ST_MUL_S: cmd_o.mul_s = 1'b1;
      ST_UPD_X: cmd_o.upd_x = 1'b1;
      ST_UPD_Y: cmd_o.upd_y = 1'b1;
      ST_OUT: begin
        if (out_free) begin
          cmd_o.out_ld = 1'b1;
          out_valid_d  = 1'b1;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

`default_nettype wire

// ===== rtl/ddpi_datapath.sv =====
// Datapath of the pose integrator: period register, pose accumulators,
// CORDIC rotator, shared multiplier, constant divider and output register.
// Depends on ddpi_pkg and ddpi_div.
`default_nettype none

module ddpi_datapath (
  input  wire                              clk_i,
  input  wire                              rst_ni,
  input  wire                              cfg_valid_i,
  input  wire [ddpi_pkg::PerW-1:0]         cfg_data_i,
  input  wire                              mode_i,
  input  wire signed [ddpi_pkg::SpdW-1:0]  speed_i,
  input  wire signed [ddpi_pkg::SpdW-1:0]  turn_rate_i,
  input  wire signed [ddpi_pkg::PosW-1:0]  load_x_i,
  input  wire signed [ddpi_pkg::PosW-1:0]  load_y_i,
  input  wire signed [ddpi_pkg::HeadW-1:0] load_heading_i,
  input  ddpi_pkg::dp_cmd_t                cmd_i,
  output ddpi_pkg::dp_sts_t                sts_o,
  output logic signed [ddpi_pkg::PosW-1:0] out_x_o,
  output logic signed [ddpi_pkg::PosW-1:0] out_y_o,
  output logic signed [ddpi_pkg::HeadW-1:0] out_heading_o
);
  import ddpi_pkg::*;

  function automatic logic signed [PosW-1:0] sat_pos(input logic signed [PosW+1:0] v);
    logic signed [PosW-1:0] r;
    if (v[PosW+1:PosW-1] == 3'b000 || v[PosW+1:PosW-1] == 3'b111) begin
      r = v[PosW-1:0];
    end else if (v[PosW+1]) begin
      r = {1'b1, {(PosW-1){1'b0}}};
    end else begin
      r = {1'b0, {(PosW-1){1'b1}}};
    end
    return r;
  endfunction

  // state and work registers
  logic [PerW-1:0]          period_q;
  logic signed [PosW-1:0]   x_acc_q, y_acc_q;
  logic signed [HeadW-1:0]  head_q;
  logic signed [SpdW-1:0]   spd_q, rate_q;
  logic signed [SpW-1:0]    sp_q, rp_q;
  logic signed [XyW-1:0]    cx_q, cy_q;
  logic signed [ZW-1:0]     cz_q;
  logic                     cneg_q;
  logic signed [ProdW-1:0]  prod_q;
  logic signed [AngW-1:0]   step_q;
  logic signed [PosW-1:0]   out_x_q, out_y_q;
  logic signed [HeadW-1:0]  out_head_q;

  logic signed [PerW:0]     per_s;
  logic signed [AngW-1:0]   head_w;
  logic signed [ZW-1:0]     z0;
  logic                     neg0;
  logic signed [XyW-1:0]    xs, ys, x_rot, y_rot;
  logic signed [ZW-1:0]     atan_z, z_rot;
  logic signed [XyW-1:0]    c_val, s_val, mul_a;
  logic [SpW-1:0]           rp_mag;
  logic [ProdW-1:0]         prod_mag;
  logic [ProdW:0]           pos_sum;
  logic [DivTW-1:0]         div_t;
  logic                     div_neg;
  logic [DivQW-1:0]         div_q;
  logic                     div_qneg;
  logic signed [DivQW:0]    dq_s;
  logic signed [AngW-1:0]   head_diff;

  assign sts_o.in_load = mode_i;

  // CORDIC seed with half-turn reduction, and one rotation step
  always_comb begin
    per_s  = $signed({1'b0, period_q});
    head_w = AngW'(head_q);
    z0     = ZW'(head_q) <<< ZAlign;
    neg0   = 1'b0;
    if (head_w > HalfPiQ13) begin
      z0   = z0 - PiQ30;
      neg0 = 1'b1;
    end else if (head_w < -HalfPiQ13) begin
      z0   = z0 + PiQ30;
      neg0 = 1'b1;
    end
    xs     = cx_q >>> cmd_i.rot_idx;
    ys     = cy_q >>> cmd_i.rot_idx;
    atan_z = $signed(ZW'(atan_q30(5'(cmd_i.rot_idx))));
    if (!cz_q[ZW-1]) begin
      x_rot = cx_q - ys;
      y_rot = cy_q + xs;
      z_rot = cz_q - atan_z;
    end else begin
      x_rot = cx_q + ys;
      y_rot = cy_q - xs;
      z_rot = cz_q + atan_z;
    end
    c_val = cneg_q ? -cx_q : cx_q;
    s_val = cneg_q ? -cy_q : cy_q;
    mul_a = cmd_i.mul_s ? s_val : c_val;
  end

  // dividend select: turn step or rounded position product
  always_comb begin
    rp_mag   = rp_q[SpW-1] ? SpW'(-rp_q) : SpW'(rp_q);
    prod_mag = prod_q[ProdW-1] ? ProdW'(-prod_q) : ProdW'(prod_q);
    pos_sum  = {1'b0, prod_mag} + PosRound;
    if (cmd_i.div_src == DIV_STEP) begin
      div_t   = DivTW'(rp_mag) + StepRound;
      div_neg = rp_q[SpW-1];
    end else begin
      div_t   = pos_sum[ProdW:PosShift];
      div_neg = prod_q[ProdW-1];
    end
  end

  ddpi_div u_div (
    .clk_i (clk_i),
    .t_i   (div_t),
    .neg_i (div_neg),
    .sel_i (cmd_i.div_src),
    .q_o   (div_q),
    .neg_o (div_qneg)
  );

  // signed quotient and heading difference
  always_comb begin
    dq_s      = div_qneg ? -$signed({1'b0, div_q}) : $signed({1'b0, div_q});
    head_diff = AngW'(head_q) - step_q;
  end

  // configuration and pose state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      period_q <= PeriodReset;
      x_acc_q  <= '0;
      y_acc_q  <= '0;
      head_q   <= '0;
    end else begin
      if (cfg_valid_i) begin
        period_q <= cfg_data_i;
      end
      if (cmd_i.accept && mode_i) begin
        x_acc_q <= load_x_i;
        y_acc_q <= load_y_i;
        head_q  <= load_heading_i;
      end
      if (cmd_i.upd_x) begin
        x_acc_q <= sat_pos((PosW + 2)'(x_acc_q) + (PosW + 2)'(dq_s));
      end
      if (cmd_i.upd_y) begin
        y_acc_q <= sat_pos((PosW + 2)'(y_acc_q) + (PosW + 2)'(dq_s));
        head_q  <= HeadW'(wrap_once(head_diff));
      end
    end
  end

  // work registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      spd_q  <= speed_i;
      rate_q <= turn_rate_i;
    end
    if (cmd_i.prep) begin
      sp_q   <= SpW'(spd_q) * SpW'(per_s);
      rp_q   <= SpW'(rate_q) * SpW'(per_s);
      cx_q   <= GainQ30;
      cy_q   <= '0;
      cz_q   <= z0;
      cneg_q <= neg0;
    end
    if (cmd_i.rot) begin
      cx_q <= x_rot;
      cy_q <= y_rot;
      cz_q <= z_rot;
    end
    if (cmd_i.step_ld) begin
      step_q <= wrap_once(AngW'(dq_s));
    end
    if (cmd_i.mul_c || cmd_i.mul_s) begin
      prod_q <= ProdW'(mul_a) * ProdW'(sp_q);
    end
    if (cmd_i.out_ld) begin
      out_x_q    <= x_acc_q;
      out_y_q    <= y_acc_q;
      out_head_q <= head_q;
    end
  end

  assign out_x_o       = out_x_q;
  assign out_y_o       = out_y_q;
  assign out_heading_o = out_head_q;

endmodule

`default_nettype wire

// ===== rtl/diff_drive_pose_integrator.sv =====
// Differential-drive dead-reckoning pose integrator, top level.
// Tick beat: seed, CORDIC rotations (shared rotator, one iteration a cycle),
// cos and sin products, divisions, then x/y and heading update and output.
// Load beat: pose loaded, then output. Beats are taken one at a time; a stalled output holds off the next.
// Reset (rst_ni low, asynchronous): pose zero, period 10 ms, no output beat.
// Depends on ddpi_pkg, ddpi_ctrl and ddpi_datapath.
`default_nettype none

module diff_drive_pose_integrator (
  input  wire                            clk_i,
  input  wire                            rst_ni,
  // configuration write: period_ms
  input  wire                            cfg_valid_i,
  output logic                           cfg_ready_o,
  input  wire [ddpi_pkg::PerW-1:0]       cfg_data_i,
  // input stream
  input  wire                            s_axis_tvalid,
  output logic                           s_axis_tready,
  // speed[15:0], turn_rate[31:16], load_x[63:32], load_y[95:64],
  // load_heading[111:96]
  input  wire [111:0]                    s_axis_tdata,
  // mode[0]: 0 tick, 1 load pose
  input  wire                            s_axis_tuser,
  // output stream
  output logic                           m_axis_tvalid,
  input  wire                            m_axis_tready,
  // out_x[31:0], out_y[63:32], out_heading[79:64]
  output logic [79:0]                    m_axis_tdata
);
  import ddpi_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  logic signed [PosW-1:0]  out_x, out_y;
  logic signed [HeadW-1:0] out_heading;

  assign cfg_ready_o = 1'b1;

  ddpi_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  ddpi_datapath u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_data_i     (cfg_data_i),
    .mode_i         (s_axis_tuser),
    .speed_i        (s_axis_tdata[15:0]),
    .turn_rate_i    (s_axis_tdata[31:16]),
    .load_x_i       (s_axis_tdata[63:32]),
    .load_y_i       (s_axis_tdata[95:64]),
    .load_heading_i (s_axis_tdata[111:96]),
    .cmd_i          (cmd),
    .sts_o          (sts),
    .out_x_o        (out_x),
    .out_y_o        (out_y),
    .out_heading_o  (out_heading)
  );

  assign m_axis_tdata = {out_heading, out_y, out_x};

endmodule

`default_nettype wire
